### sv/smalu_pkg.sv
// ----------------------------------------------------------------------------
// smalu_pkg
// Shared types and constants for the 64-bit stack machine ALU: opcodes,
// status codes, controller states and the command/result payloads.
// ----------------------------------------------------------------------------
package smalu_pkg;

  localparam int WORD_W    = 64;
  localparam int HALF_W    = WORD_W / 2;
  localparam int OP_W      = 4;
  localparam int STATUS_W  = 2;
  localparam int DEPTH_W   = 11;
  localparam int LIMIT_W   = 11;
  localparam int DEPTH_DEF = 1024;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);

  // opcodes carried in the command
  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 4'd0,
    OP_ADD  = 4'd1,
    OP_SUB  = 4'd2,
    OP_MUL  = 4'd3,
    OP_DIV  = 4'd4,
    OP_SWAP = 4'd5,
    OP_DROP = 4'd6,
    OP_DUP  = 4'd7,
    OP_POP  = 4'd8,
    OP_PEEK = 4'd9
  } op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2,
    ST_DIVZ  = 2'd3
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_MUL  = 2'd2,
    S_DIV  = 2'd3
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [WORD_W-1:0] push_value;
  } cmd_t;

  typedef struct packed {
    status_t                  status;
    logic signed [WORD_W-1:0] read_value;
    logic [DEPTH_W-1:0]       depth_after;
  } result_t;

endpackage

### sv/smalu_mem.sv
// ----------------------------------------------------------------------------
// smalu_mem
// Stack word storage: one write port, one read port, registered read data.
// Holds every entry below the top of stack.
// ----------------------------------------------------------------------------
module smalu_mem
  import smalu_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/smalu_mul.sv
// ----------------------------------------------------------------------------
// smalu_mul
// Low 64 bits of a 64x64 product, built from three 32x32 partial products
// accumulated step by step. done pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
module smalu_mul
  import smalu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  output logic              done,
  output logic [WORD_W-1:0] product
);

  localparam logic [1:0] STEP_LO = 2'd0;
  localparam logic [1:0] STEP_X1 = 2'd1;
  localparam logic [1:0] STEP_X2 = 2'd2;

  logic              active;
  logic              done_q;
  logic [1:0]        step;
  logic [WORD_W-1:0] a_q;
  logic [WORD_W-1:0] b_q;
  logic [WORD_W-1:0] acc;
  logic [HALF_W-1:0] mx;
  logic [HALF_W-1:0] my;
  logic [WORD_W-1:0] pp;
  logic [WORD_W-1:0] acc_next;

  // operand halves for the current step
  always_comb begin
    case (step)
      STEP_LO: begin
        mx = a_q[HALF_W-1:0];
        my = b_q[HALF_W-1:0];
      end
      STEP_X1: begin
        mx = a_q[HALF_W-1:0];
        my = b_q[WORD_W-1:HALF_W];
      end
      default: begin
        mx = a_q[WORD_W-1:HALF_W];
        my = b_q[HALF_W-1:0];
      end
    endcase
  end

  // one 32x32 multiply and accumulate per step
  assign pp       = {{HALF_W{1'b0}}, mx} * {{HALF_W{1'b0}}, my};
  assign acc_next = (step == STEP_LO) ? pp : acc + {pp[HALF_W-1:0], {HALF_W{1'b0}}};

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done_q <= 1'b0;
      step   <= STEP_LO;
    end else begin
      done_q <= 1'b0;
      if (start) begin
        active <= 1'b1;
        step   <= STEP_LO;
      end else if (active) begin
        step <= step + 2'd1;
        if (step == STEP_X2) begin
          active <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operand and accumulator registers
  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= a;
      b_q <= b;
    end else if (active) begin
      acc <= acc_next;
    end
  end

  assign done    = done_q;
  assign product = acc;

endmodule

### sv/smalu_div.sv
// ----------------------------------------------------------------------------
// smalu_div
// Signed 64-bit division truncating toward zero. Restoring radix-2 on the
// magnitudes, one quotient bit per cycle, sign applied at the output.
// ----------------------------------------------------------------------------
module smalu_div
  import smalu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  output logic              done,
  output logic [WORD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(WORD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

  logic              active;
  logic              done_q;
  logic [CNT_W-1:0]  cnt;
  logic              neg;
  logic [WORD_W-1:0] dvsr;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] quo;
  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   diff;
  logic              fits;
  logic [WORD_W-1:0] a_mag;
  logic [WORD_W-1:0] b_mag;

  // operand magnitudes
  assign a_mag = a[WORD_W-1] ? (~a + 1'b1) : a;
  assign b_mag = b[WORD_W-1] ? (~b + 1'b1) : b;

  // one trial subtraction per cycle
  assign shifted = {rem, quo[WORD_W-1]};
  assign diff    = shifted - {1'b0, dvsr};
  assign fits    = shifted >= {1'b0, dvsr};

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done_q <= 1'b0;
      cnt    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          active <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= a_mag;
      dvsr <= b_mag;
      neg  <= a[WORD_W-1] ^ b[WORD_W-1];
    end else if (active) begin
      rem <= fits ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
      quo <= {quo[WORD_W-2:0], fits};
    end
  end

  assign done     = done_q;
  assign quotient = neg ? (~quo + 1'b1) : quo;

endmodule

### sv/stack_machine_alu.sv
// ----------------------------------------------------------------------------
// stack_machine_alu
// 64-bit signed word stack machine. The top of stack lives in a register,
// the entries below it in a synchronous memory; a controller reads the
// second entry, updates the top and writes back.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------
//   command  | start / busy         | cmd    (op, push_value)
//   result   | done, one-cycle pulse| result (status, read_value, depth_after)
//   config   | cfg_valid / cfg_ready| cfg_data (stack limit)
//
// Commands that finish from idle without a memory read: push, dup, peek,
// unused codes, drop or pop of the last entry and every error found from
// the count alone. add, sub, swap, other drops and pops, mul and div first
// read the second entry from memory, where a divide by zero ends; mul then
// forms three 32x32 partial products, and div derives one quotient bit per cycle.
// The result pulse comes in the cycle after the work ends; the receiver has
// no stall. Reset clears the count and restores the limit; no memory sweep.
// ----------------------------------------------------------------------------
module stack_machine_alu
  import smalu_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  cmd_t               cmd,
  output logic               done,
  output result_t            result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  state_t             state;
  state_t             state_next;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [WORD_W-1:0]  top;
  logic [WORD_W-1:0]  top_next;
  logic [OP_W-1:0]    op_q;
  logic [OP_W-1:0]    op_next;
  logic               done_next;
  result_t            res;
  result_t            res_next;
  logic [LIMIT_W-1:0] limit;

  logic [CW-1:0]      count_m1;
  logic [CW-1:0]      count_m2;
  logic [CW-1:0]      count_p1;
  logic [LW-1:0]      limit_eff;
  logic               over;
  logic [WORD_W-1:0]  top_or_zero;
  logic [WORD_W-1:0]  sum;
  logic [WORD_W-1:0]  dif;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [WORD_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [WORD_W-1:0]  mem_rdata;

  logic               mul_start;
  logic               mul_done;
  logic [WORD_W-1:0]  mul_prod;
  logic               div_start;
  logic               div_done;
  logic [WORD_W-1:0]  div_quo;

  // pack a result transaction
  function automatic result_t make_res(status_t st, logic [WORD_W-1:0] rv,
                                       logic [CW-1:0] n);
    logic [LW-1:0] n_ext;
    result_t       r;
    n_ext         = LW'(n);
    r.status      = st;
    r.read_value  = rv;
    r.depth_after = n_ext[DEPTH_W-1:0];
    return r;
  endfunction

  // count arithmetic and limit check
  assign count_m1    = count - CW'(1);
  assign count_m2    = count - CW'(2);
  assign count_p1    = count + CW'(1);
  assign limit_eff   = (LW'(limit) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(limit);
  assign over        = LW'(count) >= limit_eff;
  assign top_or_zero = (count == '0) ? '0 : top;
  assign sum         = top + mem_rdata;
  assign dif         = top - mem_rdata;

  // next state and outputs
  always_comb begin
    state_next = state;
    count_next = count;
    top_next   = top;
    op_next    = op_q;
    done_next  = 1'b0;
    res_next   = res;
    mem_we     = 1'b0;
    mem_waddr  = count_m1[AW-1:0];
    mem_wdata  = top;
    mem_re     = 1'b0;
    mul_start  = 1'b0;
    div_start  = 1'b0;

    case (state)
      S_IDLE: begin
        if (start) begin
          done_next = 1'b1;
          case (cmd.op)
            OP_PUSH: begin
              if (over) begin
                res_next = make_res(ST_OVER, top_or_zero, count);
              end else begin
                mem_we     = (count != '0);
                top_next   = cmd.push_value;
                count_next = count_p1;
                res_next   = make_res(ST_OK, cmd.push_value, count_p1);
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SWAP: begin
              if (count < CW'(2)) begin
                res_next = make_res(ST_UNDER, top_or_zero, count);
              end else begin
                done_next  = 1'b0;
                mem_re     = 1'b1;
                op_next    = cmd.op;
                state_next = S_READ;
              end
            end
            OP_DROP, OP_POP: begin
              if (count == '0) begin
                res_next = make_res(ST_UNDER, '0, count);
              end else if (count == CW'(1)) begin
                count_next = '0;
                res_next   = make_res(ST_OK, (cmd.op == OP_POP) ? top : '0, '0);
              end else begin
                done_next  = 1'b0;
                mem_re     = 1'b1;
                op_next    = cmd.op;
                state_next = S_READ;
              end
            end
            OP_DUP: begin
              if (count == '0) begin
                res_next = make_res(ST_UNDER, '0, count);
              end else if (over) begin
                res_next = make_res(ST_OVER, top, count);
              end else begin
                mem_we     = 1'b1;
                count_next = count_p1;
                res_next   = make_res(ST_OK, top, count_p1);
              end
            end
            OP_PEEK: begin
              if (count == '0) begin
                res_next = make_res(ST_UNDER, '0, count);
              end else begin
                res_next = make_res(ST_OK, top, count);
              end
            end
            default: begin
              res_next = make_res(ST_OK, top_or_zero, count);
            end
          endcase
        end
      end

      // second entry is on the read port
      S_READ: begin
        state_next = S_IDLE;
        done_next  = 1'b1;
        case (op_q)
          OP_ADD: begin
            top_next   = sum;
            count_next = count_m1;
            res_next   = make_res(ST_OK, sum, count_m1);
          end
          OP_SUB: begin
            top_next   = dif;
            count_next = count_m1;
            res_next   = make_res(ST_OK, dif, count_m1);
          end
          OP_SWAP: begin
            mem_we    = 1'b1;
            mem_waddr = count_m2[AW-1:0];
            top_next  = mem_rdata;
            res_next  = make_res(ST_OK, mem_rdata, count);
          end
          OP_DROP: begin
            top_next   = mem_rdata;
            count_next = count_m1;
            res_next   = make_res(ST_OK, mem_rdata, count_m1);
          end
          OP_POP: begin
            top_next   = mem_rdata;
            count_next = count_m1;
            res_next   = make_res(ST_OK, top, count_m1);
          end
          OP_MUL: begin
            done_next  = 1'b0;
            mul_start  = 1'b1;
            state_next = S_MUL;
          end
          OP_DIV: begin
            if (mem_rdata == '0) begin
              res_next = make_res(ST_DIVZ, top, count);
            end else begin
              done_next  = 1'b0;
              div_start  = 1'b1;
              state_next = S_DIV;
            end
          end
          default: begin
            res_next = make_res(ST_OK, top_or_zero, count);
          end
        endcase
      end

      S_MUL: begin
        if (mul_done) begin
          top_next   = mul_prod;
          count_next = count_m1;
          res_next   = make_res(ST_OK, mul_prod, count_m1);
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_DIV: begin
        if (div_done) begin
          top_next   = div_quo;
          count_next = count_m1;
          res_next   = make_res(ST_OK, div_quo, count_m1);
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    top  <= top_next;
    op_q <= op_next;
    res  <= res_next;
  end

  // stack limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit <= cfg_data;
    end
  end

  assign busy      = (state != S_IDLE);
  assign result    = res;
  assign cfg_ready = 1'b1;

  smalu_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (count_m2[AW-1:0]),
    .rdata (mem_rdata)
  );

  smalu_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (top),
    .b       (mem_rdata),
    .done    (mul_done),
    .product (mul_prod)
  );

  smalu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .a        (top),
    .b        (mem_rdata),
    .done     (div_done),
    .quotient (div_quo)
  );

endmodule
